FILE: sv/btiu_pkg.sv
// Shared types, codes and constant tables of the bracketed turtle interpreter.
// No dependencies; imported by every module of the block.
`default_nettype none

package btiu_pkg;

    localparam int HEADING_STEPS = 12;
    localparam int POS_W         = 24;
    localparam int HEAD_W        = 4;
    localparam int BAL_W         = 16;
    localparam int LEN_W         = 10;
    localparam int ORG_W         = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 12;
    localparam int TRIG_W        = 16;

    localparam logic [LEN_W-1:0] SEG_LEN_RST  = 10'd100;
    localparam logic [ORG_W-1:0] ORIGIN_X_RST = 12'd200;
    localparam logic [ORG_W-1:0] ORIGIN_Y_RST = 12'd400;

    typedef enum logic [2:0] {
        SYM_STEP   = 3'd0,
        SYM_PLUS   = 3'd1,
        SYM_MINUS  = 3'd2,
        SYM_PUSH   = 3'd3,
        SYM_POP    = 3'd4,
        SYM_IGNORE = 3'd5
    } t_symbol;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEG_LEN     = 3'd0,
        CFG_MIRROR      = 3'd1,
        CFG_START_COLOR = 3'd2,
        CFG_ORIGIN_X    = 3'd3,
        CFG_ORIGIN_Y    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEN_W-1:0] seg_len;
        logic             mirror;
        logic             start_color;
        logic [ORG_W-1:0] origin_x;
        logic [ORG_W-1:0] origin_y;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [HEAD_W-1:0] h;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stk_ctl;

    // sin(h*30deg) in Q2.14
    function automatic logic signed [TRIG_W-1:0] sin_q14(input logic [HEAD_W-1:0] h);
        logic signed [TRIG_W-1:0] v;
        unique case (h)
            4'd0:    v = 16'sd0;
            4'd1:    v = 16'sd8192;
            4'd2:    v = 16'sd14189;
            4'd3:    v = 16'sd16384;
            4'd4:    v = 16'sd14189;
            4'd5:    v = 16'sd8192;
            4'd6:    v = 16'sd0;
            4'd7:    v = -16'sd8192;
            4'd8:    v = -16'sd14189;
            4'd9:    v = -16'sd16384;
            4'd10:   v = -16'sd14189;
            4'd11:   v = -16'sd8192;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // -cos(h*30deg) in Q2.14, y grows downward
    function automatic logic signed [TRIG_W-1:0] ncos_q14(input logic [HEAD_W-1:0] h);
        logic signed [TRIG_W-1:0] v;
        unique case (h)
            4'd0:    v = -16'sd16384;
            4'd1:    v = -16'sd14189;
            4'd2:    v = -16'sd8192;
            4'd3:    v = 16'sd0;
            4'd4:    v = 16'sd8192;
            4'd5:    v = 16'sd14189;
            4'd6:    v = 16'sd16384;
            4'd7:    v = 16'sd14189;
            4'd8:    v = 16'sd8192;
            4'd9:    v = 16'sd0;
            4'd10:   v = -16'sd8192;
            4'd11:   v = -16'sd14189;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: sv/btiu_cfg_regs.sv
// Configuration register file of the turtle interpreter.
// Depends on btiu_pkg for register codes, reset values and the t_cfg struct.
`default_nettype none

module btiu_cfg_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_wr_en,
    input  wire logic [btiu_pkg::CFG_IDX_W-1:0]      i_wr_index,
    input  wire logic [btiu_pkg::CFG_DATA_W-1:0]     i_wr_data,
    output btiu_pkg::t_cfg                           o_cfg
);
    import btiu_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_SEG_LEN:     n_cfg.seg_len     = i_wr_data[LEN_W-1:0];
                CFG_MIRROR:      n_cfg.mirror      = i_wr_data[0];
                CFG_START_COLOR: n_cfg.start_color = i_wr_data[0];
                CFG_ORIGIN_X:    n_cfg.origin_x    = i_wr_data[ORG_W-1:0];
                CFG_ORIGIN_Y:    n_cfg.origin_y    = i_wr_data[ORG_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seg_len     <= SEG_LEN_RST;
            r_cfg.mirror      <= 1'b0;
            r_cfg.start_color <= 1'b0;
            r_cfg.origin_x    <= ORIGIN_X_RST;
            r_cfg.origin_y    <= ORIGIN_Y_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: sv/btiu_stack.sv
// Save stack for position and heading: top and next entry held in registers,
// deeper entries in a memory with registered read. Depends on btiu_pkg.
`default_nettype none

module btiu_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire btiu_pkg::t_stk_ctl                 i_ctl,
    input  wire btiu_pkg::t_entry                   i_push_data,
    output logic [$clog2(STACK_DEPTH+1)-1:0]        o_level,
    output btiu_pkg::t_entry                        o_top
);
    import btiu_pkg::*;

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);

    logic [LVL_W-1:0] r_level;
    logic [LVL_W-1:0] n_level;
    logic [LVL_W-1:0] base_lvl;
    logic [LVL_W-1:0] wr_lvl;
    logic [LVL_W-1:0] rd_lvl;
    t_entry           r_mem [STACK_DEPTH];
    t_entry           r_top;
    t_entry           r_below;

    always_comb begin
        base_lvl = i_ctl.clear ? '0 : r_level;
        n_level  = base_lvl;
        if (i_ctl.push) begin
            n_level = base_lvl + LVL_W'(1);
        end else if (i_ctl.pop) begin
            n_level = base_lvl - LVL_W'(1);
        end
    end

    assign wr_lvl = base_lvl - LVL_W'(1);
    assign rd_lvl = base_lvl - LVL_W'(3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else begin
            r_level <= n_level;
        end
    end

    // old top spills into the memory on push; next entry refills on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (base_lvl != '0) begin
                r_mem[wr_lvl[ADDR_W-1:0]] <= r_top;
            end
            r_top   <= i_push_data;
            r_below <= r_top;
        end else if (i_ctl.pop) begin
            r_top   <= r_below;
            r_below <= r_mem[rd_lvl[ADDR_W-1:0]];
        end
    end

    assign o_level = r_level;
    assign o_top   = r_top;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_W'(STACK_DEPTH))
        else $error("stack level beyond depth");

    a_push_pop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ctl.push && i_ctl.pop))
        else $error("push and pop in one cycle");

    a_push_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |=> r_level != '0)
        else $error("stack empty after push");

    a_clear_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear && !i_ctl.push && !i_ctl.pop |=> r_level == '0)
        else $error("stack not empty after clear");

endmodule

`default_nettype wire

FILE: sv/bracketed_turtle_interpreter_unit.sv
// Bracketed L-system turtle interpreter, one symbol word in, one result word out.
// Depends on btiu_pkg, btiu_cfg_regs and btiu_stack.
//
// Input channel (i_in_valid/o_in_ready) takes symbol, first and last. Each word
// gives exactly one result word on the output channel (o_out_valid/i_out_ready):
// drawn, segment start and end (signed, 8 fraction bits), pen color, stack
// overflow and, on a last word, the balance flag.
// Configuration writes come on i_cfg_valid/o_cfg_ready with a register index and
// data; o_cfg_ready is always high. Write only while no word is in flight.
// An accepted word sits in the input register, is interpreted combinationally
// and lands in the result register when it advances; o_out_valid is high after it.
// Throughput: one word per cycle while the receiver is ready, set by the
// combinational turtle state update (one 10x16 multiply and a 24-bit add per axis).
// If the receiver stalls, the result register holds and the input register
// keeps one more word; o_in_ready drops only when both are full.
// Synchronous active-low reset restores register defaults, puts the turtle at
// the default origin with heading up, empties the stack and clears both stages.
`default_nettype none

module bracketed_turtle_interpreter_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [2:0]                         i_symbol,
    input  wire logic                               i_first,
    input  wire logic                               i_last,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic                                    o_drawn,
    output logic signed [btiu_pkg::POS_W-1:0]       o_x_start,
    output logic signed [btiu_pkg::POS_W-1:0]       o_y_start,
    output logic signed [btiu_pkg::POS_W-1:0]       o_x_end,
    output logic signed [btiu_pkg::POS_W-1:0]       o_y_end,
    output logic                                    o_pen_color,
    output logic                                    o_stack_overflow,
    output logic                                    o_balanced,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [btiu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [btiu_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import btiu_pkg::*;

    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int PROD_W = LEN_W + 1 + TRIG_W;
    localparam int DLT_W  = PROD_W - 6;

    t_cfg             cfg;
    t_stk_ctl         stk_ctl;
    t_entry           stk_push;
    t_entry           stk_top;
    logic [LVL_W-1:0] stk_level;

    logic             in_acc;
    logic             adv;

    logic             r_a_valid;
    logic [2:0]       r_a_sym;
    logic             r_a_first;
    logic             r_a_last;

    logic [POS_W-1:0]  r_x, n_x;
    logic [POS_W-1:0]  r_y, n_y;
    logic [HEAD_W-1:0] r_head, n_head;
    logic              r_color, n_color;
    logic [BAL_W-1:0]  r_bal, n_bal;

    logic [POS_W-1:0]  base_x, base_y;
    logic [HEAD_W-1:0] base_head;
    logic              base_color;
    logic [BAL_W-1:0]  base_bal;
    logic [LVL_W-1:0]  base_lvl;
    logic              cw;
    logic              is_push, is_pop;

    logic signed [PROD_W-1:0] prod_x, prod_y;
    logic signed [PROD_W-1:0] rnd_x, rnd_y;
    logic signed [DLT_W-1:0]  dlt_x, dlt_y;

    logic              n_drawn, n_ovf, n_balanced;
    logic [POS_W-1:0]  n_xs, n_ys, n_xe, n_ye;
    logic              n_pen;

    logic              r_out_valid;
    logic              r_drawn, r_ovf, r_balanced, r_pen;
    logic [POS_W-1:0]  r_xs, r_ys, r_xe, r_ye;

    btiu_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    btiu_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stk_ctl),
        .i_push_data (stk_push),
        .o_level     (stk_level),
        .o_top       (stk_top)
    );

    assign o_cfg_ready = 1'b1;

    assign adv        = r_a_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_a_valid || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_sym   <= i_symbol;
            r_a_first <= i_first;
            r_a_last  <= i_last;
        end
    end

    always_comb begin
        base_x     = r_a_first ? POS_W'({cfg.origin_x, 8'h00}) : r_x;
        base_y     = r_a_first ? POS_W'({cfg.origin_y, 8'h00}) : r_y;
        base_head  = r_a_first ? '0 : r_head;
        base_color = r_a_first ? cfg.start_color : r_color;
        base_bal   = r_a_first ? '0 : r_bal;
        base_lvl   = r_a_first ? '0 : stk_level;

        prod_x = $signed({1'b0, cfg.seg_len}) * sin_q14(base_head);
        prod_y = $signed({1'b0, cfg.seg_len}) * ncos_q14(base_head);
        rnd_x  = prod_x + PROD_W'(32);
        rnd_y  = prod_y + PROD_W'(32);
        dlt_x  = DLT_W'(rnd_x >>> 6);
        dlt_y  = DLT_W'(rnd_y >>> 6);

        n_x        = base_x;
        n_y        = base_y;
        n_head     = base_head;
        n_color    = base_color;
        n_bal      = base_bal;
        n_drawn    = 1'b0;
        n_ovf      = 1'b0;
        n_xs       = '0;
        n_ys       = '0;
        n_xe       = '0;
        n_ye       = '0;
        n_pen      = 1'b0;
        is_push    = 1'b0;
        is_pop     = 1'b0;
        cw         = (t_symbol'(r_a_sym) == SYM_PLUS) ? !cfg.mirror : cfg.mirror;

        unique case (t_symbol'(r_a_sym))
            SYM_STEP: begin
                n_color = !base_color;
                n_x     = base_x + POS_W'(dlt_x);
                n_y     = base_y + POS_W'(dlt_y);
                n_drawn = 1'b1;
                n_xs    = base_x;
                n_ys    = base_y;
                n_xe    = n_x;
                n_ye    = n_y;
                n_pen   = n_color;
            end
            SYM_PLUS, SYM_MINUS: begin
                if (cw) begin
                    n_head = (base_head == HEAD_W'(HEADING_STEPS - 1)) ? '0
                                                                      : base_head + 1'b1;
                end else begin
                    n_head = (base_head == '0) ? HEAD_W'(HEADING_STEPS - 1)
                                               : base_head - 1'b1;
                end
            end
            SYM_PUSH: begin
                n_bal = base_bal + 1'b1;
                if (base_lvl == LVL_W'(STACK_DEPTH)) begin
                    n_ovf = 1'b1;
                end else begin
                    is_push = 1'b1;
                end
            end
            SYM_POP: begin
                n_bal = base_bal - 1'b1;
                if (base_lvl != '0) begin
                    is_pop = 1'b1;
                    n_x    = stk_top.x;
                    n_y    = stk_top.y;
                    n_head = stk_top.h;
                end
            end
            default: begin
                n_head = base_head;
            end
        endcase

        n_balanced = r_a_last && (n_bal == '0);
    end

    assign stk_ctl.clear = adv && r_a_first;
    assign stk_ctl.push  = adv && is_push;
    assign stk_ctl.pop   = adv && is_pop;
    assign stk_push.x    = base_x;
    assign stk_push.y    = base_y;
    assign stk_push.h    = base_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= POS_W'({ORIGIN_X_RST, 8'h00});
            r_y         <= POS_W'({ORIGIN_Y_RST, 8'h00});
            r_head      <= '0;
            r_color     <= 1'b0;
            r_bal       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_x     <= n_x;
                r_y     <= n_y;
                r_head  <= n_head;
                r_color <= n_color;
                r_bal   <= n_bal;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_drawn    <= n_drawn;
            r_xs       <= n_xs;
            r_ys       <= n_ys;
            r_xe       <= n_xe;
            r_ye       <= n_ye;
            r_pen      <= n_pen;
            r_ovf      <= n_ovf;
            r_balanced <= n_balanced;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_drawn          = r_drawn;
    assign o_x_start        = r_xs;
    assign o_y_start        = r_ys;
    assign o_x_end          = r_xe;
    assign o_y_end          = r_ye;
    assign o_pen_color      = r_pen;
    assign o_stack_overflow = r_ovf;
    assign o_balanced       = r_balanced;

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < HEAD_W'(HEADING_STEPS))
        else $error("heading out of range");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("interpreted word not presented");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_drawn |->
            r_xs == '0 && r_ys == '0 && r_xe == '0 && r_ye == '0 && !r_pen)
        else $error("segment fields set without a segment");

    a_ovf_only_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && n_ovf |-> stk_level == LVL_W'(STACK_DEPTH) && !r_a_first)
        else $error("overflow flagged below full stack");

endmodule

`default_nettype wire
